// ----- rtl/ubds_pkg.sv -----
package ubds_pkg;

  localparam int CLK_W   = 28;
  localparam int BAUD_W  = 24;
  localparam int OSR_W   = 7;
  localparam int RATIO_W = 6;
  localparam int DIV_W   = 16;
  localparam int ERR_W   = 32;

  localparam int DEN1_W = BAUD_W + OSR_W;
  localparam int DEN2_W = DIV_W + OSR_W;
  localparam int DEN3_W = DIV_W + 1 + OSR_W;

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(48000000);

  localparam int RECIP_W   = 25;
  localparam int RECIP_SH  = 31;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(21474837);
  localparam int PROD_W    = BAUD_W + RECIP_W;
  localparam int Q100_W    = 18;
  localparam int LIM_W     = Q100_W + 2;

  typedef struct packed {
    logic [BAUD_W-1:0] baud;
    logic [OSR_W-1:0]  osr;
    logic              first;
    logic              last;
    logic [Q100_W-1:0] q100;
  } side1_t;

  typedef struct packed {
    logic [BAUD_W-1:0] baud;
    logic              first;
    logic              last;
    logic [LIM_W-1:0]  limit;
  } side2_t;

  typedef struct packed {
    logic [OSR_W-1:0] osr;
    logic [DIV_W-1:0] div;
  } side3_t;

endpackage

// ----- rtl/ubds_ifc.sv -----
interface ubds_baud_if;
  logic                       valid;
  logic                       ready;
  logic [ubds_pkg::BAUD_W-1:0] requested_baud;
  modport source (output valid, output requested_baud, input ready);
  modport sink (input valid, input requested_baud, output ready);
endinterface

interface ubds_result_if;
  logic                        valid;
  logic                        ready;
  logic                        rejected;
  logic [ubds_pkg::RATIO_W-1:0] oversample_ratio;
  logic [ubds_pkg::DIV_W-1:0]   baud_divisor;
  logic                        both_edge;
  modport source (output valid, output rejected, output oversample_ratio,
                  output baud_divisor, output both_edge, input ready);
  modport sink (input valid, input rejected, input oversample_ratio,
                input baud_divisor, input both_edge, output ready);
endinterface

interface ubds_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ubds_pkg::CLK_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ubds_div_cell.sv -----
module ubds_div_cell #(
  parameter int NW = 28,
  parameter int DW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [DW-1:0] den_in,
  input  logic [DW-1:0] rem_in,
  input  logic [NW-1:0] num_in,
  input  logic [NW-1:0] quo_in,
  input  logic [SW-1:0] side_in,
  output logic          valid,
  output logic [DW-1:0] den,
  output logic [DW-1:0] rem,
  output logic [NW-1:0] num,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side
);

  logic [DW:0] trial;
  logic        ge;
  logic [DW:0] diff;

  assign trial = {rem_in, num_in[NW-1]};
  assign ge    = trial >= {1'b0, den_in};
  assign diff  = trial - {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den  <= den_in;
      rem  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num  <= {num_in[NW-2:0], 1'b0};
      quo  <= {quo_in[NW-2:0], ge};
      side <= side_in;
    end
  end

endmodule

// ----- rtl/ubds_div_chain.sv -----
module ubds_div_chain #(
  parameter int NW = 28,
  parameter int DW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] den_in,
  input  logic [SW-1:0] side_in,
  output logic          valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side
);

  logic          v_a [NW+1];
  logic [DW-1:0] d_a [NW+1];
  logic [DW-1:0] r_a [NW+1];
  logic [NW-1:0] n_a [NW+1];
  logic [NW-1:0] q_a [NW+1];
  logic [SW-1:0] s_a [NW+1];

  assign v_a[0] = valid_in;
  assign d_a[0] = den_in;
  assign r_a[0] = '0;
  assign n_a[0] = num_in;
  assign q_a[0] = '0;
  assign s_a[0] = side_in;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    ubds_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (v_a[i]),
      .den_in   (d_a[i]),
      .rem_in   (r_a[i]),
      .num_in   (n_a[i]),
      .quo_in   (q_a[i]),
      .side_in  (s_a[i]),
      .valid    (v_a[i+1]),
      .den      (d_a[i+1]),
      .rem      (r_a[i+1]),
      .num      (n_a[i+1]),
      .quo      (q_a[i+1]),
      .side     (s_a[i+1])
    );
  end

  assign valid = v_a[NW];
  assign quo   = q_a[NW];
  assign side  = s_a[NW];

endmodule

// ----- rtl/uart_baud_divisor_search.sv -----
// channel | dir | word                                   | accepted when
// cfg     | in  | module_clock_hz                        | cfg.valid & cfg.ready
// req     | in  | requested_baud                         | req.valid & req.ready
// res     | out | rejected, ratio, divisor, both_edge    | res.valid & res.ready
//
// One ratio enters the divider row per cycle while the row is not held; the
// single ratio issuer steps from OSR_MIN to OSR_MAX per request and takes the
// next one on its last ratio. A result passes the e register, a row of 28
// cells, the f register, two parallel rows of 28, the g and out registers.
// Reset is synchronous; the clock register returns to 48000000.
// The whole row holds only while a finished result waits and the next one
// is already at the tail; else the issuer takes a request when idle or on OSR_MAX.
module uart_baud_divisor_search #(
  parameter int OSR_MIN = 4,
  parameter int OSR_MAX = 32
) (
  input logic               clk,
  input logic               rst,
  ubds_cfg_if.sink          cfg,
  ubds_baud_if.sink         req,
  ubds_result_if.source     res
);

  localparam logic [ubds_pkg::OSR_W-1:0] OMIN = ubds_pkg::OSR_W'(OSR_MIN);
  localparam logic [ubds_pkg::OSR_W-1:0] OMAX = ubds_pkg::OSR_W'(OSR_MAX);

  logic [ubds_pkg::CLK_W-1:0]  clk_hz;
  logic                        adv;

  logic                        busy;
  logic [ubds_pkg::OSR_W-1:0]  osr;
  logic [ubds_pkg::BAUD_W-1:0] baud_r;
  logic                        tok_last;
  logic                        in_take;

  logic                        e_valid;
  logic [ubds_pkg::DEN1_W-1:0] e_den;
  logic [ubds_pkg::PROD_W-1:0] e_prod;
  logic [ubds_pkg::BAUD_W-1:0] e_baud;
  logic [ubds_pkg::OSR_W-1:0]  e_osr;
  logic                        e_first;
  logic                        e_last;
  ubds_pkg::side1_t            s1_in;
  ubds_pkg::side1_t            s1_out;

  logic                        c1_valid;
  logic [ubds_pkg::CLK_W-1:0]  c1_quo;
  logic [ubds_pkg::DIV_W-1:0]  div_fix;

  logic                        f_valid;
  logic [ubds_pkg::DEN2_W-1:0] f_den2;
  logic [ubds_pkg::DEN3_W-1:0] f_den3;
  ubds_pkg::side2_t            s2_in;
  ubds_pkg::side2_t            s2_out;
  ubds_pkg::side3_t            s3_in;
  ubds_pkg::side3_t            s3_out;

  logic                        c2_valid;
  logic                        c3_valid;
  logic [ubds_pkg::CLK_W-1:0]  c2_quo;
  logic [ubds_pkg::CLK_W-1:0]  c3_quo;
  logic [ubds_pkg::ERR_W-1:0]  err_dn;
  logic [ubds_pkg::ERR_W-1:0]  err_up;
  logic                        pick_up;

  logic                        g_valid;
  logic [ubds_pkg::ERR_W-1:0]  g_err;
  logic [ubds_pkg::DIV_W-1:0]  g_div;
  logic [ubds_pkg::OSR_W-1:0]  g_osr;
  logic [ubds_pkg::BAUD_W-1:0] g_baud;
  logic                        g_first;
  logic                        g_last;
  logic [ubds_pkg::LIM_W-1:0]  g_limit;

  logic [ubds_pkg::ERR_W-1:0]  best_err;
  logic [ubds_pkg::OSR_W-1:0]  best_osr;
  logic [ubds_pkg::DIV_W-1:0]  best_div;
  logic [ubds_pkg::ERR_W-1:0]  cur_err;
  logic [ubds_pkg::OSR_W-1:0]  cur_osr;
  logic [ubds_pkg::DIV_W-1:0]  cur_div;
  logic                        take;
  logic [ubds_pkg::ERR_W-1:0]  best_err_next;
  logic [ubds_pkg::OSR_W-1:0]  best_osr_next;
  logic [ubds_pkg::DIV_W-1:0]  best_div_next;
  logic                        rej;

  logic                        out_valid;
  logic                        out_rej;
  logic [ubds_pkg::RATIO_W-1:0] out_ratio;
  logic [ubds_pkg::DIV_W-1:0]  out_div;
  logic                        out_both;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz <= ubds_pkg::CLK_RESET;
    end else if (cfg.valid) begin
      clk_hz <= cfg.data;
    end
  end

  // hold everything only when the tail word would overwrite a waiting result
  assign adv = !(out_valid && !res.ready && g_valid && g_last);

  assign tok_last  = osr == OMAX;
  assign req.ready = !rst && adv && (!busy || tok_last);
  assign in_take   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      osr  <= OMIN;
    end else if (adv) begin
      if (in_take) begin
        busy <= 1'b1;
        osr  <= OMIN;
      end else if (busy) begin
        if (tok_last) begin
          busy <= 1'b0;
        end else begin
          osr <= osr + ubds_pkg::OSR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      baud_r <= req.requested_baud;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_den   <= ubds_pkg::DEN1_W'(baud_r) * ubds_pkg::DEN1_W'(osr);
      e_prod  <= ubds_pkg::PROD_W'(baud_r) * ubds_pkg::PROD_W'(ubds_pkg::RECIP_100);
      e_baud  <= baud_r;
      e_osr   <= osr;
      e_first <= osr == OMIN;
      e_last  <= tok_last;
    end
  end

  assign s1_in.baud  = e_baud;
  assign s1_in.osr   = e_osr;
  assign s1_in.first = e_first;
  assign s1_in.last  = e_last;
  assign s1_in.q100  = e_prod[ubds_pkg::RECIP_SH +: ubds_pkg::Q100_W];

  ubds_div_chain #(
    .NW(ubds_pkg::CLK_W), .DW(ubds_pkg::DEN1_W), .SW($bits(ubds_pkg::side1_t))
  ) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .valid_in (e_valid),
    .num_in   (clk_hz),
    .den_in   (e_den),
    .side_in  (s1_in),
    .valid    (c1_valid),
    .quo      (c1_quo),
    .side     (s1_out)
  );

  assign div_fix = (c1_quo[ubds_pkg::DIV_W-1:0] == '0) ? ubds_pkg::DIV_W'(1)
                                                       : c1_quo[ubds_pkg::DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_den2      <= ubds_pkg::DEN2_W'(div_fix) * ubds_pkg::DEN2_W'(s1_out.osr);
      f_den3      <= (ubds_pkg::DEN3_W'(div_fix) + ubds_pkg::DEN3_W'(1))
                     * ubds_pkg::DEN3_W'(s1_out.osr);
      s2_in.baud  <= s1_out.baud;
      s2_in.first <= s1_out.first;
      s2_in.last  <= s1_out.last;
      s2_in.limit <= ubds_pkg::LIM_W'({s1_out.q100, 1'b0})
                     + ubds_pkg::LIM_W'(s1_out.q100);
      s3_in.osr   <= s1_out.osr;
      s3_in.div   <= div_fix;
    end
  end

  ubds_div_chain #(
    .NW(ubds_pkg::CLK_W), .DW(ubds_pkg::DEN2_W), .SW($bits(ubds_pkg::side2_t))
  ) u_div2 (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .valid_in (f_valid),
    .num_in   (clk_hz),
    .den_in   (f_den2),
    .side_in  (s2_in),
    .valid    (c2_valid),
    .quo      (c2_quo),
    .side     (s2_out)
  );

  ubds_div_chain #(
    .NW(ubds_pkg::CLK_W), .DW(ubds_pkg::DEN3_W), .SW($bits(ubds_pkg::side3_t))
  ) u_div3 (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .valid_in (f_valid),
    .num_in   (clk_hz),
    .den_in   (f_den3),
    .side_in  (s3_in),
    .valid    (c3_valid),
    .quo      (c3_quo),
    .side     (s3_out)
  );

  assign err_dn  = ubds_pkg::ERR_W'(c2_quo) - ubds_pkg::ERR_W'(s2_out.baud);
  assign err_up  = ubds_pkg::ERR_W'(s2_out.baud) - ubds_pkg::ERR_W'(c3_quo);
  assign pick_up = err_dn > err_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_err   <= pick_up ? err_up : err_dn;
      g_div   <= pick_up ? s3_out.div + ubds_pkg::DIV_W'(1) : s3_out.div;
      g_osr   <= s3_out.osr;
      g_baud  <= s2_out.baud;
      g_first <= s2_out.first;
      g_last  <= s2_out.last;
      g_limit <= s2_out.limit;
    end
  end

  always_comb begin
    cur_err       = g_first ? ubds_pkg::ERR_W'(g_baud) : best_err;
    cur_osr       = g_first ? '0 : best_osr;
    cur_div       = g_first ? '0 : best_div;
    take          = g_err <= cur_err;
    best_err_next = take ? g_err : cur_err;
    best_osr_next = take ? g_osr : cur_osr;
    best_div_next = take ? g_div : cur_div;
    rej           = best_err_next > ubds_pkg::ERR_W'(g_limit);
  end

  always_ff @(posedge clk) begin
    if (adv && g_valid) begin
      best_err <= best_err_next;
      best_osr <= best_osr_next;
      best_div <= best_div_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && g_valid && g_last) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && g_valid && g_last) begin
      out_rej   <= rej;
      out_ratio <= rej ? '0 : best_osr_next[ubds_pkg::RATIO_W-1:0];
      out_div   <= rej ? '0 : best_div_next;
      out_both  <= !rej && best_osr_next > ubds_pkg::OSR_W'(3)
                   && best_osr_next < ubds_pkg::OSR_W'(8);
    end
  end

  assign res.valid            = out_valid;
  assign res.rejected         = out_rej;
  assign res.oversample_ratio = out_ratio;
  assign res.baud_divisor     = out_div;
  assign res.both_edge        = out_both;

`ifndef SYNTHESIS
  a_osr_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (osr >= OMIN && osr <= OMAX))
    else $error("ratio counter out of range");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    adv && g_valid && g_last |=> res.valid)
    else $error("finished search did not reach the output");

  a_no_take_on_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready && g_valid && g_last |-> !req.ready)
    else $error("request taken while row is held");

  a_rows_aligned: assert property (@(posedge clk) disable iff (rst)
    c2_valid == c3_valid)
    else $error("divider rows out of step");
`endif

endmodule
